[rtl/pli_pkg.sv]
// pli_pkg: shared types and constants of the piecewise linear interpolator
// holds the command item passed from the front end through the queue to the back end
// no dependencies

package pli_pkg;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef struct packed {
        logic        is_query;
        logic        slot_ok;
        logic [6:0]  idx;
        logic [31:0] a;
        logic [31:0] b;
        logic        last;
    } t_cmd;

endpackage

[rtl/pli_front.sv]
// pli_front: input register and item classification
// depends on pli_pkg; feeds pli_queue

module pli_front import pli_pkg::*; #(
    parameter int MAX_POINTS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [6:0]  i_point_index,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic [31:0] i_query_value,
    input  logic        i_last_query,
    output logic        o_push,
    output t_cmd        o_cmd,
    input  logic        i_full
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    assign o_in_stall = r_valid && i_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_full;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_cmd.is_query = (i_operation == OP_QUERY);
        n_cmd.slot_ok  = (32'(i_point_index) < 32'(MAX_POINTS));
        n_cmd.idx      = i_point_index;
        n_cmd.a        = (i_operation == OP_QUERY) ? i_query_value : i_point_x;
        n_cmd.b        = i_point_y;
        n_cmd.last     = i_last_query;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

[rtl/pli_queue.sv]
// pli_queue: short command queue between front end and back end
// depends on pli_pkg

module pli_queue import pli_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

[rtl/pli_back.sv]
// pli_back: breakpoint memory, segment scan, multiply and serial divide, result register
// depends on pli_pkg; takes commands from pli_queue

module pli_back import pli_pkg::*; #(
    parameter int MAX_POINTS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_q_valid,
    input  t_cmd        i_q_cmd,
    output logic        o_q_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_interp_value,
    output logic        o_found,
    output logic        o_batch_end
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = (IW + 1 > 8) ? IW + 1 : 8;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_FIRST = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_PREP  = 9'b000001000,
        S_MAG   = 9'b000010000,
        S_MUL   = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_FIN   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic [7:0]    r_points;
    logic [63:0]   r_mem [MAX_POINTS];
    logic [63:0]   r_rd;
    logic [63:0]   r_prev;
    logic [31:0]   r_q;
    logic          r_last;
    logic [IW-1:0] r_k;
    logic [31:0]   r_dx;
    logic [31:0]   r_t;
    logic [32:0]   r_dy;
    logic [31:0]   r_y0;
    logic          r_neg;
    logic [31:0]   r_mag;
    logic [31:0]   r_rem;
    logic [31:0]   r_dq;
    logic [4:0]    r_cnt;
    logic [31:0]   r_res;
    logic          r_found;
    logic          r_out_valid;
    logic [31:0]   r_out_value;
    logic          r_out_found;
    logic          r_out_last;

    logic [CW-1:0] pts_ext;
    logic [CW-1:0] pts;
    logic          wr_en;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [31:0]   prev_x;
    logic [31:0]   cur_x;
    logic          match;
    logic          scan_end;
    logic          out_load;
    logic [32:0]   div_sh;
    logic          div_bit;
    logic [32:0]   div_diff;
    logic [63:0]   prod;
    logic [33:0]   sum;

    assign pts_ext  = CW'(r_points);
    assign pts      = (pts_ext > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : pts_ext;
    assign prev_x   = r_prev[63:32];
    assign cur_x    = r_rd[63:32];
    assign match    = ($signed(r_q) >= $signed(prev_x)) && ($signed(r_q) <= $signed(cur_x));
    assign scan_end = ((CW'(r_k) + CW'(1)) >= pts);
    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign div_sh   = {r_rem, r_dq[31]};
    assign div_diff = div_sh - {1'b0, r_dx};
    assign div_bit  = (div_sh >= {1'b0, r_dx});
    assign prod     = r_mag * r_t;
    assign sum      = r_neg ? ({{2{r_y0[31]}}, r_y0} - {2'b00, r_dq})
                            : ({{2{r_y0[31]}}, r_y0} + {2'b00, r_dq});

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        wr_en   = 1'b0;
        rd_en   = 1'b0;
        rd_addr = '0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (!i_q_cmd.is_query) begin
                        wr_en = i_q_cmd.slot_ok;
                    end else if (pts < CW'(2)) begin
                        n_state = S_DONE;
                    end else begin
                        rd_en   = 1'b1;
                        n_state = S_FIRST;
                    end
                end
            end
            S_FIRST: begin
                rd_en   = 1'b1;
                rd_addr = IW'(1);
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (match) begin
                    n_state = S_PREP;
                end else if (scan_end) begin
                    n_state = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_k + 1'b1;
                end
            end
            S_PREP: n_state = S_MAG;
            S_MAG: begin
                n_state = (r_dx == '0) ? S_DONE : S_MUL;
            end
            S_MUL: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == 5'd31) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_points    <= 8'd2;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_points <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // breakpoint memory, x in the upper half and y in the lower half
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[IW'(i_q_cmd.idx)] <= {i_q_cmd.a, i_q_cmd.b};
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_q     <= i_q_cmd.a;
                r_last  <= i_q_cmd.last;
                r_res   <= '0;
                r_found <= 1'b0;
            end
            S_FIRST: begin
                r_prev <= r_rd;
                r_k    <= IW'(1);
            end
            S_SCAN: begin
                if (!match && !scan_end) begin
                    r_prev <= r_rd;
                    r_k    <= r_k + 1'b1;
                end
            end
            S_PREP: begin
                r_dx <= cur_x - prev_x;
                r_t  <= r_q - prev_x;
                r_dy <= {r_rd[31], r_rd[31:0]} - {r_prev[31], r_prev[31:0]};
                r_y0 <= r_prev[31:0];
            end
            S_MAG: begin
                r_neg <= r_dy[32];
                r_mag <= r_dy[32] ? 32'(~r_dy + 33'd1) : r_dy[31:0];
                if (r_dx == '0) begin
                    r_res   <= r_y0;
                    r_found <= 1'b1;
                end
            end
            S_MUL: begin
                // quotient fits 32 bits, so the upper product half is already below dx
                r_rem <= prod[63:32];
                r_dq  <= prod[31:0];
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem <= div_bit ? div_diff[31:0] : div_sh[31:0];
                r_dq  <= {r_dq[30:0], div_bit};
                r_cnt <= r_cnt + 1'b1;
            end
            S_FIN: begin
                r_found <= 1'b1;
                if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
                    r_res <= sum[31:0];
                end else if (sum[33]) begin
                    r_res <= 32'h8000_0000;
                end else begin
                    r_res <= 32'h7FFF_FFFF;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value <= r_res;
            r_out_found <= r_found;
            r_out_last  <= r_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_interp_value = r_out_value;
    assign o_found        = r_out_found;
    assign o_batch_end    = r_out_last;

endmodule

[rtl/piecewise_linear_interpolator_top.sv]
// piecewise_linear_interpolator_top: top level of the piecewise linear interpolator
// depends on pli_pkg, pli_front, pli_queue, pli_back

// Load items write one (x, y) breakpoint into the table and give no result; query items
// scan segments in order and give one result each, in arrival order. A query scans up to
// points_in_use - 1 segments (one breakpoint memory read per cycle), then runs a
// multiply and a serial restoring divider. A four-entry queue lets the input side keep
// accepting while the back end works, and an output register holds a finished result
// while the next query is computed. The user must write points_in_use through the cfg
// channel only while the block is idle; the block itself does not enforce it.

module piecewise_linear_interpolator_top import pli_pkg::*; #(
    parameter int MAX_POINTS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [6:0]  i_point_index,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic [31:0] i_query_value,
    input  logic        i_last_query,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_interp_value,
    output logic        o_found,
    output logic        o_batch_end,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    logic push;
    logic full;
    logic q_valid;
    logic q_pop;
    t_cmd f_cmd;
    t_cmd q_cmd;

    assign o_cfg_ready = 1'b1;

    pli_front #(
        .MAX_POINTS(MAX_POINTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_point_index(i_point_index),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_query_value(i_query_value),
        .i_last_query (i_last_query),
        .o_push       (push),
        .o_cmd        (f_cmd),
        .i_full       (full)
    );

    pli_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (f_cmd),
        .o_full (full),
        .o_valid(q_valid),
        .o_cmd  (q_cmd),
        .i_pop  (q_pop)
    );

    pli_back #(
        .MAX_POINTS(MAX_POINTS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_cmd),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_interp_value(o_interp_value),
        .o_found       (o_found),
        .o_batch_end   (o_batch_end)
    );

endmodule

[rtl/pli_checker.sv]
// pli_checker: port-level assertions on the interpolator top level
// bound to piecewise_linear_interpolator_top; no package dependency

module pli_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_operation,
    input logic [6:0]  i_point_index,
    input logic [31:0] i_point_x,
    input logic [31:0] i_point_y,
    input logic [31:0] i_query_value,
    input logic        i_last_query,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_interp_value,
    input logic        o_found,
    input logic        o_batch_end,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [7:0]  i_cfg_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_interp_value)
            && $stable(o_found) && $stable(o_batch_end))
        else $error("stalled result changed");

    // a miss always reads zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_interp_value == 32'd0)
        else $error("miss with nonzero value");

    // reset leaves nothing pending and the input open
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("state left after reset");

    // a stalled result is never dropped: valid stays high
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_out_valid) && $past(i_out_stall) && $past(i_rst_n) |-> o_out_valid)
        else $error("result dropped under stall");

endmodule

bind piecewise_linear_interpolator_top pli_checker u_pli_checker (.*);

[tb/sv/tb_piecewise_linear_interpolator_top.sv]
`timescale 1ns / 100ps
// tb_piecewise_linear_interpolator_top: self-checking testbench for the interpolator top level
// directed rows then random phases of table loads and queries, checked against a local predictor
// depends on pli_pkg and piecewise_linear_interpolator_top

module tb_piecewise_linear_interpolator_top;
    import pli_pkg::*;

    localparam int TBL_DEPTH    = 128;
    localparam int QUIET_CYCLES = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int N_PHASES     = 10;

    typedef struct packed {
        logic        op;
        logic [6:0]  idx;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] q;
        logic        last_q;
    } t_item;

    typedef struct packed {
        logic [31:0] value;
        logic        found;
        logic        batch_end;
    } t_interp;

    typedef struct packed {
        t_item   it;
        logic    typed;
        t_interp res;
    } t_row;

    typedef struct packed {
        logic [7:0] pts;
        logic [6:0] send_idle;
        logic [6:0] recv_stall;
        logic [9:0] n_items;
        logic       reload;
        logic       pressure;
    } t_phase;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        i_operation   = OP_LOAD;
    logic [6:0]  i_point_index = '0;
    logic [31:0] i_point_x     = '0;
    logic [31:0] i_point_y     = '0;
    logic [31:0] i_query_value = '0;
    logic        i_last_query  = 1'b0;
    logic        i_out_stall   = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic [7:0]  i_cfg_data    = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_interp_value;
    logic        o_found;
    logic        o_batch_end;
    logic        o_cfg_ready;

    // predictor state
    logic [31:0] tbl_x [TBL_DEPTH];
    logic [31:0] tbl_y [TBL_DEPTH];
    logic [7:0]  npoints = 8'd2;

    t_interp     interp_due [$];
    t_row        dir_rows [$];
    int unsigned send_idle  = 0;
    int unsigned recv_stall = 0;
    bit          hold_req   = 1'b0;
    bit          hold_taken = 1'b0;
    int unsigned hold_left  = 0;
    int unsigned cycle_count = 0;
    int unsigned err_count   = 0;

    piecewise_linear_interpolator_top #(
        .MAX_POINTS(TBL_DEPTH)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_operation(i_operation),
        .i_point_index(i_point_index),
        .i_point_x(i_point_x),
        .i_point_y(i_point_y),
        .i_query_value(i_query_value),
        .i_last_query(i_last_query),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_interp_value(o_interp_value),
        .o_found(o_found),
        .o_batch_end(o_batch_end),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        err_count++;
    endtask

    function automatic void store_breakpoint(input logic [6:0] idx, input logic [31:0] x,
                                             input logic [31:0] y);
        if (idx < TBL_DEPTH) begin
            tbl_x[idx] = x;
            tbl_y[idx] = y;
        end
    endfunction

    // first segment holding q, exact slope product, truncating division
    function automatic t_interp interpolate(input logic [31:0] q_bits, input logic last_q);
        t_interp         r;
        int              n;
        longint          q;
        longint          x0;
        longint          x1;
        longint          y0;
        longint          y1;
        longint          dy;
        longint          acc;
        longint unsigned dx;
        longint unsigned t;
        longint unsigned mag;
        longint unsigned quo;
        r.value     = '0;
        r.found     = 1'b0;
        r.batch_end = last_q;
        n = (npoints > TBL_DEPTH) ? TBL_DEPTH : int'(npoints);
        q = longint'($signed(q_bits));
        for (int s = 0; s + 1 < n && !r.found; s++) begin
            x0 = longint'($signed(tbl_x[s]));
            x1 = longint'($signed(tbl_x[s + 1]));
            if (q >= x0 && q <= x1) begin
                r.found = 1'b1;
                y0 = longint'($signed(tbl_y[s]));
                y1 = longint'($signed(tbl_y[s + 1]));
                dx = x1 - x0;
                t  = q - x0;
                dy = y1 - y0;
                if (dx == 0) begin
                    acc = y0;
                end else begin
                    mag = (dy < 0) ? -dy : dy;
                    quo = (mag * t) / dx;
                    acc = (dy < 0) ? y0 - longint'(quo) : y0 + longint'(quo);
                end
                if (acc > 64'sd2147483647) begin
                    acc = 64'sd2147483647;
                end
                if (acc < -64'sd2147483648) begin
                    acc = -64'sd2147483648;
                end
                r.value = acc[31:0];
            end
        end
        return r;
    endfunction

    function automatic t_item random_fields();
        t_item it;
        it.op     = 1'($urandom_range(1));
        it.idx    = 7'($urandom_range(127));
        it.x      = $urandom;
        it.y      = $urandom;
        it.q      = $urandom;
        it.last_q = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic void add_load(input logic [6:0] idx, input logic [31:0] x,
                                     input logic [31:0] y);
        t_row r;
        r.it     = random_fields();
        r.it.op  = OP_LOAD;
        r.it.idx = idx;
        r.it.x   = x;
        r.it.y   = y;
        r.typed  = 1'b0;
        r.res    = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_query(input logic [31:0] q, input logic last_q,
                                      input logic typed, input logic [31:0] value,
                                      input logic found);
        t_row r;
        r.it               = random_fields();
        r.it.op            = OP_QUERY;
        r.it.q             = q;
        r.it.last_q        = last_q;
        r.typed            = typed;
        r.res.value        = value;
        r.res.found        = found;
        r.res.batch_end    = last_q;
        dir_rows.push_back(r);
    endfunction

    function automatic void build_directed();
        // slope two segment, endpoints and outside on both sides
        add_load(7'd0, 32'h0000_0000, 32'h0000_0000);
        add_load(7'd1, 32'h0001_0000, 32'h0002_0000);
        add_query(32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b1);
        add_query(32'h0001_0000, 1'b0, 1'b1, 32'h0002_0000, 1'b1);
        add_query(32'h0000_8000, 1'b0, 1'b1, 32'h0001_0000, 1'b1);
        add_query(32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 1'b0);
        add_query(32'h0001_0001, 1'b0, 1'b1, 32'h0000_0000, 1'b0);
        add_query(32'h7FFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 1'b0);
        add_query(32'h8000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0);
        // full range segment with full range fall
        add_load(7'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        add_load(7'd1, 32'h7FFF_FFFF, 32'h8000_0000);
        add_query(32'h8000_0000, 1'b0, 1'b1, 32'h7FFF_FFFF, 1'b1);
        add_query(32'h7FFF_FFFF, 1'b0, 1'b1, 32'h8000_0000, 1'b1);
        add_query(32'h0000_0000, 1'b1, 1'b0, '0, 1'b0);
        add_query(32'h1234_5678, 1'b0, 1'b0, '0, 1'b0);
        // zero width segment
        add_load(7'd0, 32'h0000_0005, 32'h0000_0064);
        add_load(7'd1, 32'h0000_0005, 32'hFFFF_FFF9);
        add_query(32'h0000_0005, 1'b0, 1'b1, 32'h0000_0064, 1'b1);
        add_query(32'h0000_0006, 1'b1, 1'b1, 32'h0000_0000, 1'b0);
        // falling segment across zero, truncation toward zero
        add_load(7'd0, 32'hFFFF_0000, 32'h0003_0000);
        add_load(7'd1, 32'h0002_0000, 32'hFFFD_0000);
        add_query(32'h0000_0001, 1'b0, 1'b0, '0, 1'b0);
        add_query(32'hFFFF_8001, 1'b1, 1'b0, '0, 1'b0);
        add_load(7'd127, 32'h7FFF_FFFF, 32'h8000_0000);
        add_load(7'd126, 32'h8000_0000, 32'h7FFF_FFFF);
    endfunction

    // columns: points, sender idle %, receiver stall %, items, reload table, long hold
    function automatic t_phase phase_plan(input int k);
        t_phase ph;
        case (k)
            0:       ph = {8'd1,   7'd0,  7'd0,  10'd30,  1'b1, 1'b0};
            1:       ph = {8'd3,   7'd0,  7'd0,  10'd130, 1'b1, 1'b1};
            2:       ph = {8'd8,   7'd73, 7'd0,  10'd130, 1'b1, 1'b0};
            3:       ph = {8'd128, 7'd0,  7'd73, 10'd50,  1'b1, 1'b0};
            4:       ph = {8'd255, 7'd24, 7'd24, 10'd30,  1'b0, 1'b0};
            5:       ph = {8'd16,  7'd0,  7'd73, 10'd120, 1'b1, 1'b0};
            6:       ph = {8'd5,   7'd24, 7'd24, 10'd120, 1'b1, 1'b0};
            7:       ph = {8'd2,   7'd73, 7'd0,  10'd60,  1'b1, 1'b0};
            8:       ph = {8'd0,   7'd24, 7'd24, 10'd30,  1'b0, 1'b0};
            default: ph = {8'd200, 7'd0,  7'd0,  10'd20,  1'b0, 1'b0};
        endcase
        return ph;
    endfunction

    function automatic t_item random_item(input int eff);
        t_item  it;
        int     s;
        longint lo;
        longint span;
        it = random_fields();
        if ($urandom_range(3) == 0) begin
            it.op = OP_LOAD;
            if (eff > 0 && $urandom_range(1) == 1) begin
                it.idx = 7'($urandom_range(eff - 1));
            end
            if ($urandom_range(1) == 1) begin
                it.y = $signed($urandom) >>> $urandom_range(0, 31);
            end
        end else begin
            it.op = OP_QUERY;
            if (eff >= 2 && $urandom_range(9) < 7) begin
                s    = $urandom_range(eff - 2);
                lo   = longint'($signed(tbl_x[s]));
                span = longint'($signed(tbl_x[s + 1])) - lo;
                if ($urandom_range(3) == 0) begin
                    it.q = tbl_x[s + $urandom_range(1)];
                end else if (span >= 0) begin
                    it.q = 32'(lo + longint'($urandom) % (span + 1));
                end
            end else if ($urandom_range(1) == 1) begin
                it.q = $signed($urandom) >>> $urandom_range(0, 31);
            end
        end
        return it;
    endfunction

    // offer one item, hold it until the transfer, then predict
    task automatic apply(input t_item it, input logic typed, input t_interp typed_res);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= it.op;
        i_point_index <= it.idx;
        i_point_x     <= it.x;
        i_point_y     <= it.y;
        i_query_value <= it.q;
        i_last_query  <= it.last_q;
        do @(posedge i_clk); while (o_in_stall);
        if (it.op == OP_LOAD) begin
            store_breakpoint(it.idx, it.x, it.y);
        end else begin
            interp_due.push_back(typed ? typed_res : interpolate(it.q, it.last_q));
        end
    endtask

    task automatic load_sorted_table(input int eff);
        t_item  it;
        longint cur;
        cur = longint'($signed($urandom) >>> $urandom_range(0, 31));
        if ($urandom_range(7) == 0) begin
            cur = -64'sd2147483648;
        end
        for (int i = 0; i < eff; i++) begin
            it     = random_fields();
            it.op  = OP_LOAD;
            it.idx = 7'(i);
            it.x   = cur[31:0];
            it.y   = $signed($urandom) >>> $urandom_range(0, 31);
            apply(it, 1'b0, '0);
            cur += ($urandom_range(15) == 0) ? 64'sd0 : longint'($urandom >> $urandom_range(0, 31));
            if (cur > 64'sd2147483647) begin
                cur = 64'sd2147483647;
            end
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (interp_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_point_count(input logic [7:0] count);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= count;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        npoints = count;
    endtask

    // receiver side, with one long hold to back up the block
    always @(posedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall);
        end
    end

    always @(posedge i_clk) begin
        t_interp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (interp_due.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing expected", o_interp_value));
            end else begin
                want = interp_due.pop_front();
                if (o_interp_value !== want.value) begin
                    report_mismatch($sformatf("interp_value %h, expected %h",
                                              o_interp_value, want.value));
                end
                if (o_found !== want.found) begin
                    report_mismatch($sformatf("found %b, expected %b", o_found, want.found));
                end
                if (o_batch_end !== want.batch_end) begin
                    report_mismatch($sformatf("batch_end %b, expected %b",
                                              o_batch_end, want.batch_end));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("piecewise_linear_interpolator_top verification failed");
            $finish;
        end
    end

    initial begin
        t_phase ph;
        int     eff;
        build_directed();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_rows[k]) begin
            apply(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].res);
        end
        for (int p = 0; p < N_PHASES; p++) begin
            ph = phase_plan(p);
            settle();
            write_point_count(ph.pts);
            send_idle  = 32'(ph.send_idle);
            recv_stall = 32'(ph.recv_stall);
            if (ph.pressure) begin
                hold_req = 1'b1;
            end
            eff = (ph.pts > TBL_DEPTH) ? TBL_DEPTH : int'(ph.pts);
            if (ph.reload) begin
                load_sorted_table(eff);
            end
            repeat (ph.n_items) apply(random_item(eff), 1'b0, '0);
        end
        settle();
        if (err_count == 0) begin
            $display("piecewise_linear_interpolator_top verification clean");
        end else begin
            $display("piecewise_linear_interpolator_top verification failed");
        end
        $finish;
    end

endmodule
